FILE: hw/rtl/sitd_pkg.sv
// Shared constants and types for the signed integer to radix digits block.
// No dependencies; used by every module under hw/rtl.
`default_nettype none

package sitd_pkg;

    localparam int MAX_SYMBOLS_DEF = 64;
    localparam int STORE_BYTES     = 64;
    localparam int WORD_COUNT      = 8;
    localparam int WORD_W          = 64;
    localparam int WORD_SEL_W      = $clog2(WORD_COUNT);
    localparam int BYTE_SEL_W      = $clog2(WORD_W / 8);
    localparam int SYM_IDX_W       = $clog2(STORE_BYTES);
    localparam int LEN_W           = $clog2(STORE_BYTES + 1);
    localparam int CFG_IDX_W       = 8;
    localparam int SYM_W           = 8;
    localparam int VALUE_W         = 32;
    localparam int DIV_CHUNK       = 8;
    localparam int DIV_STEPS       = VALUE_W / DIV_CHUNK;
    localparam int STEP_W          = $clog2(DIV_STEPS);
    localparam int MAX_DIGITS      = VALUE_W;
    localparam int ND_W            = $clog2(MAX_DIGITS + 1);

    localparam logic [SYM_W-1:0] MINUS_SIGN    = 8'd45;
    localparam logic [SYM_W-1:0] PLUS_SIGN     = 8'd43;
    localparam logic [SYM_W-1:0] LOWEST_SYMBOL = 8'd33;
    localparam logic [SYM_W-1:0] DEL_SYMBOL    = 8'd127;

    typedef struct packed {
        logic             ready;
        logic             valid;
        logic [LEN_W-1:0] len;
    } t_alpha_status;

endpackage

`default_nettype wire

FILE: hw/rtl/signed_integer_to_radix_digits.sv
// Top level: sequencer for signed integer to radix digit conversion.
// Depends on sitd_pkg, sitd_alphabet and sitd_div_step.
//
// Usage: write alphabet words 0..7 on the cfg channel (valid/ready, index, data;
// ready is always high, indexes above 7 are dropped). After a word write the block
// scans the alphabet one symbol per cycle, restarting on each new word write, and
// holds busy high meanwhile. Pulse start with i_value while busy is low to begin
// a transaction. The block answers with one character per o_symbol_valid strobe:
// '-' for a negative value, then digits most significant first, the last one
// flagged on o_final_symbol. An invalid alphabet yields no characters and the
// accepted value is dropped with busy staying low.
// Timing: each digit is divided out through the shared divide unit, one byte of the
// dividend per cycle, then the sign and the digits are emitted in turn. The last
// character is on the outputs in the cycle after busy's last high cycle.
// Reset clears the alphabet to all zeros, which is invalid.
// The receiver cannot stall: each strobe lasts exactly one cycle.
`default_nettype none

module signed_integer_to_radix_digits #(
    parameter int MAX_SYMBOLS = sitd_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic signed [sitd_pkg::VALUE_W-1:0] i_value,
    output logic                                o_symbol_valid,
    output logic      [sitd_pkg::SYM_W-1:0]     o_symbol,
    output logic                                o_final_symbol,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [sitd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [sitd_pkg::WORD_W-1:0]    i_cfg_data
);

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_SIGN, S_EMIT} t_state;

    t_state                          r_state;
    logic                            r_neg;
    logic [sitd_pkg::VALUE_W-1:0]    r_mag;
    logic [sitd_pkg::SYM_IDX_W-1:0]  r_rem;
    logic [sitd_pkg::STEP_W-1:0]     r_step;
    logic [sitd_pkg::ND_W-1:0]       r_nd;
    logic [sitd_pkg::SYM_IDX_W-1:0]  r_stack [sitd_pkg::MAX_DIGITS];
    logic                            r_out_valid;
    logic [sitd_pkg::SYM_W-1:0]      r_out_sym;
    logic                            r_out_final;

    sitd_pkg::t_alpha_status         status;
    logic [sitd_pkg::SYM_W-1:0]      rd_sym;
    logic [sitd_pkg::SYM_IDX_W-1:0]  div_rem;
    logic [sitd_pkg::DIV_CHUNK-1:0]  div_quo;
    logic [sitd_pkg::VALUE_W-1:0]    n_mag;
    logic                            accept;

    sitd_alphabet #(
        .MAX_SYMBOLS(MAX_SYMBOLS)
    ) u_alphabet (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_rd_idx    (r_stack[0]),
        .o_rd_sym    (rd_sym),
        .o_status    (status)
    );

    sitd_div_step u_div (
        .i_rem     (r_rem),
        .i_chunk   (r_mag[sitd_pkg::VALUE_W-1 -: sitd_pkg::DIV_CHUNK]),
        .i_divisor (status.len),
        .o_rem     (div_rem),
        .o_quo     (div_quo)
    );

    assign n_mag          = {r_mag[sitd_pkg::VALUE_W-sitd_pkg::DIV_CHUNK-1:0], div_quo};
    assign busy           = (r_state != S_IDLE) || !status.ready;
    assign accept         = start && !busy;
    assign o_cfg_ready    = 1'b1;
    assign o_symbol_valid = r_out_valid;
    assign o_symbol       = r_out_sym;
    assign o_final_symbol = r_out_final;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_nd        <= '0;
            r_step      <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_out_valid <= 1'b0;
                    if (accept && status.valid) begin
                        r_neg   <= i_value[sitd_pkg::VALUE_W-1];
                        r_mag   <= i_value[sitd_pkg::VALUE_W-1] ?
                                   (~i_value) + 1'b1 : i_value;
                        r_rem   <= '0;
                        r_step  <= '0;
                        r_nd    <= '0;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_out_valid <= 1'b0;
                    r_mag       <= n_mag;
                    r_step      <= r_step + 1'b1;
                    if (r_step == sitd_pkg::STEP_W'(sitd_pkg::DIV_STEPS - 1)) begin
                        r_rem      <= '0;
                        r_stack[0] <= div_rem;
                        for (int k = 1; k < sitd_pkg::MAX_DIGITS; k++) begin
                            r_stack[k] <= r_stack[k-1];
                        end
                        r_nd <= r_nd + 1'b1;
                        if (n_mag == '0 ||
                            r_nd == sitd_pkg::ND_W'(sitd_pkg::MAX_DIGITS - 1)) begin
                            r_state <= r_neg ? S_SIGN : S_EMIT;
                        end
                    end else begin
                        r_rem <= div_rem;
                    end
                end
                S_SIGN: begin
                    r_out_valid <= 1'b1;
                    r_out_sym   <= sitd_pkg::MINUS_SIGN;
                    r_out_final <= 1'b0;
                    r_state     <= S_EMIT;
                end
                S_EMIT: begin
                    r_out_valid <= 1'b1;
                    r_out_sym   <= rd_sym;
                    r_out_final <= (r_nd == sitd_pkg::ND_W'(1));
                    r_nd        <= r_nd - 1'b1;
                    for (int k = 0; k < sitd_pkg::MAX_DIGITS - 1; k++) begin
                        r_stack[k] <= r_stack[k+1];
                    end
                    if (r_nd == sitd_pkg::ND_W'(1)) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_out_valid <= 1'b0;
                    r_state     <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sitd_div_step.sv
// Shared divide unit: eight restoring division steps of a byte by the radix.
// Depends on sitd_pkg.
`default_nettype none

module sitd_div_step (
    input  wire logic [sitd_pkg::SYM_IDX_W-1:0] i_rem,
    input  wire logic [sitd_pkg::DIV_CHUNK-1:0] i_chunk,
    input  wire logic [sitd_pkg::LEN_W-1:0]     i_divisor,
    output logic      [sitd_pkg::SYM_IDX_W-1:0] o_rem,
    output logic      [sitd_pkg::DIV_CHUNK-1:0] o_quo
);

    logic [sitd_pkg::LEN_W-1:0] rem;
    logic [sitd_pkg::LEN_W-1:0] trial;

    always_comb begin
        rem   = {1'b0, i_rem};
        trial = '0;
        o_quo = '0;
        for (int k = sitd_pkg::DIV_CHUNK - 1; k >= 0; k--) begin
            trial = {rem[sitd_pkg::LEN_W-2:0], i_chunk[k]};
            if (trial >= i_divisor) begin
                rem      = trial - i_divisor;
                o_quo[k] = 1'b1;
            end else begin
                rem = trial;
            end
        end
        o_rem = rem[sitd_pkg::SYM_IDX_W-1:0];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sitd_alphabet.sv
// Alphabet store; scans length and validity one symbol per cycle unless written.
// Depends on sitd_pkg.
`default_nettype none

module sitd_alphabet #(
    parameter int MAX_SYMBOLS = sitd_pkg::MAX_SYMBOLS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_valid,
    input  wire logic [sitd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [sitd_pkg::WORD_W-1:0]        i_cfg_data,
    input  wire logic [sitd_pkg::SYM_IDX_W-1:0]     i_rd_idx,
    output logic      [sitd_pkg::SYM_W-1:0]         o_rd_sym,
    output sitd_pkg::t_alpha_status                 o_status
);

    localparam logic [sitd_pkg::SYM_IDX_W-1:0] LAST_IDX =
        sitd_pkg::SYM_IDX_W'(MAX_SYMBOLS - 1);
    localparam logic [sitd_pkg::LEN_W-1:0] CAP_LEN = sitd_pkg::LEN_W'(MAX_SYMBOLS);

    logic [sitd_pkg::WORD_W-1:0]    r_word [sitd_pkg::WORD_COUNT];
    logic                           r_dirty;
    logic                           r_scan;
    logic [sitd_pkg::SYM_IDX_W-1:0] r_idx;
    logic [sitd_pkg::LEN_W-1:0]     r_len;
    logic                           r_ok;
    logic [127:0]                   r_seen;

    logic [sitd_pkg::SYM_IDX_W-1:0] addr;
    logic [sitd_pkg::SYM_W-1:0]     sym;
    logic                           bad;

    always_comb begin
        addr = r_scan ? r_idx : i_rd_idx;
        sym  = r_word[addr[sitd_pkg::SYM_IDX_W-1 -: sitd_pkg::WORD_SEL_W]]
                     [addr[sitd_pkg::BYTE_SEL_W-1:0] * 8 +: sitd_pkg::SYM_W];
        bad  = (sym < sitd_pkg::LOWEST_SYMBOL) || (sym >= sitd_pkg::DEL_SYMBOL) ||
               (sym == sitd_pkg::PLUS_SIGN) || (sym == sitd_pkg::MINUS_SIGN) ||
               r_seen[sym[6:0]];
    end

    assign o_rd_sym       = sym;
    assign o_status.ready = !r_dirty && !r_scan;
    assign o_status.valid = r_ok;
    assign o_status.len   = r_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < sitd_pkg::WORD_COUNT; w++) begin
                r_word[w] <= '0;
            end
            r_dirty <= 1'b1;
            r_scan  <= 1'b0;
            r_ok    <= 1'b0;
            r_len   <= '0;
            r_idx   <= '0;
            r_seen  <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index < sitd_pkg::CFG_IDX_W'(sitd_pkg::WORD_COUNT)) begin
                r_word[i_cfg_index[sitd_pkg::WORD_SEL_W-1:0]] <= i_cfg_data;
                r_dirty <= 1'b1;
                r_scan  <= 1'b0;
            end
        end else if (r_dirty) begin
            r_dirty <= 1'b0;
            r_scan  <= 1'b1;
            r_idx   <= '0;
            r_seen  <= '0;
            r_ok    <= 1'b0;
        end else if (r_scan) begin
            if (sym == '0) begin
                r_scan <= 1'b0;
                r_len  <= sitd_pkg::LEN_W'(r_idx);
                r_ok   <= (r_idx >= sitd_pkg::SYM_IDX_W'(2));
            end else if (bad) begin
                r_scan <= 1'b0;
                r_len  <= sitd_pkg::LEN_W'(r_idx);
                r_ok   <= 1'b0;
            end else if (r_idx == LAST_IDX) begin
                r_scan <= 1'b0;
                r_len  <= CAP_LEN;
                r_ok   <= 1'b1;
            end else begin
                r_seen[sym[6:0]] <= 1'b1;
                r_idx            <= r_idx + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench for signed_integer_to_radix_digits: loads digit alphabets over the
// register channel, converts signed values and checks every emitted character and end flag.
// Depends on sitd_pkg and the signed_integer_to_radix_digits RTL.
module tb;

    localparam int unsigned STALL_LIMIT  = 3000;
    localparam int unsigned TAIL_CYCLES  = 250;
    localparam int unsigned REPORT_CAP   = 100;
    localparam int unsigned ALPHA_WORD_0 = 0;
    localparam int unsigned SYMBOL_SLOTS = sitd_pkg::STORE_BYTES;
    localparam int unsigned RADIX_CAP    = sitd_pkg::MAX_SYMBOLS_DEF;

    typedef struct packed {
        logic [sitd_pkg::SYM_W-1:0] symbol;
        logic                       last_char;
    } t_glyph;

    typedef enum int {
        FAULT_EMPTY,
        FAULT_SINGLE,
        FAULT_LOW,
        FAULT_DEL,
        FAULT_HIGH,
        FAULT_PLUS,
        FAULT_MINUS,
        FAULT_REPEAT,
        FAULT_KINDS
    } t_fault;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic signed [sitd_pkg::VALUE_W-1:0] i_value;
    logic                                o_symbol_valid;
    logic [sitd_pkg::SYM_W-1:0]          o_symbol;
    logic                                o_final_symbol;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [sitd_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [sitd_pkg::WORD_W-1:0]         i_cfg_data;

    logic [sitd_pkg::WORD_W-1:0] alpha_word [sitd_pkg::WORD_COUNT];
    logic [7:0]                  alpha_draft [SYMBOL_SLOTS];
    int unsigned                 draft_len;
    t_glyph                      pending_glyphs [$];

    int unsigned error_count      = 0;
    int unsigned values_sent      = 0;
    int unsigned glyphs_checked   = 0;
    int unsigned alphabets_loaded = 0;
    int unsigned radix_lo         = RADIX_CAP;
    int unsigned radix_hi         = 0;
    int unsigned idle_pct         = 0;
    int unsigned stall_cycles     = 0;

    signed_integer_to_radix_digits u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .o_symbol_valid (o_symbol_valid),
        .o_symbol       (o_symbol),
        .o_final_symbol (o_final_symbol),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [7:0] symbol_at(int unsigned pos);
        return alpha_word[pos[5:3]][pos[2:0] * 8 +: 8];
    endfunction

    function automatic int unsigned radix_length();
        int unsigned n;
        n = 0;
        while (n < RADIX_CAP && n < SYMBOL_SLOTS && symbol_at(n) != 8'h00) n++;
        return n;
    endfunction

    function automatic bit alphabet_ok(int unsigned len);
        logic [7:0] c;
        if (len < 2) return 1'b0;
        for (int unsigned i = 0; i < len; i++) begin
            c = symbol_at(i);
            if (c < sitd_pkg::LOWEST_SYMBOL || c >= sitd_pkg::DEL_SYMBOL ||
                c == sitd_pkg::PLUS_SIGN || c == sitd_pkg::MINUS_SIGN) return 1'b0;
            for (int unsigned j = i + 1; j < len; j++)
                if (symbol_at(j) == c) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void predict_glyphs(logic [31:0] raw);
        int unsigned len;
        logic [31:0] mag;
        int unsigned digit_idx [$];
        t_glyph      g;
        len = radix_length();
        if (!alphabet_ok(len)) return;
        mag = raw;
        if (raw[31]) begin
            mag = ~raw + 32'd1;
            g.symbol    = sitd_pkg::MINUS_SIGN;
            g.last_char = 1'b0;
            pending_glyphs.push_back(g);
        end
        do begin
            digit_idx.push_front(mag % len);
            mag = mag / len;
        end while (mag != 0);
        foreach (digit_idx[i]) begin
            g.symbol    = symbol_at(digit_idx[i]);
            g.last_char = (i == digit_idx.size() - 1);
            pending_glyphs.push_back(g);
        end
    endfunction

    function automatic void draft_text(string s);
        for (int i = 0; i < SYMBOL_SLOTS; i++)
            alpha_draft[i] = (i < s.len()) ? s[i] : 8'h00;
        draft_len = s.len();
    endfunction

    function automatic void draft_distinct(int unsigned len);
        logic [7:0]  pool [$];
        int unsigned k;
        for (int v = sitd_pkg::LOWEST_SYMBOL; v < sitd_pkg::DEL_SYMBOL; v++)
            if (v != sitd_pkg::PLUS_SIGN && v != sitd_pkg::MINUS_SIGN) pool.push_back(8'(v));
        for (int i = 0; i < SYMBOL_SLOTS; i++) begin
            if (i < len) begin
                k = $urandom_range(pool.size() - 1);
                alpha_draft[i] = pool[k];
                pool.delete(k);
            end else if (i == len) begin
                alpha_draft[i] = 8'h00;
            end else begin
                alpha_draft[i] = 8'($urandom_range(255));
            end
        end
        draft_len = len;
    endfunction

    function automatic void draft_corrupt(t_fault f);
        int unsigned pos;
        int unsigned src;
        pos = $urandom_range(draft_len - 1);
        case (f)
            FAULT_EMPTY:  alpha_draft[0] = 8'h00;
            FAULT_SINGLE: alpha_draft[1] = 8'h00;
            FAULT_LOW:    alpha_draft[pos] = 8'($urandom_range(sitd_pkg::LOWEST_SYMBOL - 1, 1));
            FAULT_DEL:    alpha_draft[pos] = sitd_pkg::DEL_SYMBOL;
            FAULT_HIGH:   alpha_draft[pos] = 8'($urandom_range(255, 128));
            FAULT_PLUS:   alpha_draft[pos] = sitd_pkg::PLUS_SIGN;
            FAULT_MINUS:  alpha_draft[pos] = sitd_pkg::MINUS_SIGN;
            FAULT_REPEAT: begin
                src = $urandom_range(draft_len - 2);
                pos = $urandom_range(draft_len - 1, src + 1);
                alpha_draft[pos] = alpha_draft[src];
            end
            default: ;
        endcase
    endfunction

    function automatic logic [31:0] random_value();
        int unsigned pick;
        int unsigned radix;
        int unsigned k;
        logic [31:0] p;
        pick  = $urandom_range(99);
        radix = radix_length();
        if (radix < 2) radix = 10;
        if (pick < 50) return $urandom;
        if (pick < 70) return $urandom_range(40) - 20;
        if (pick < 88) begin
            p = 1;
            k = $urandom_range(31);
            repeat (k) if (p <= 32'hFFFF_FFFF / radix) p = p * radix;
            p = p + $urandom_range(2) - 1;
            return $urandom_range(1) ? -p : p;
        end
        case ($urandom_range(4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        if (error_count <= REPORT_CAP) $display("ERROR at %0t: %s", $time, what);
    endtask

    task automatic send_value(logic [31:0] v);
        if ($urandom_range(99) < idle_pct) begin
            repeat ($urandom_range(60, 1)) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start   <= 1'b1;
        i_value <= v;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        predict_glyphs(v);
        values_sent++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_glyphs.size() != 0) @(negedge i_clk);
        repeat (TAIL_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [sitd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [sitd_pkg::WORD_W-1:0] data);
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        if (idx < sitd_pkg::WORD_COUNT) alpha_word[idx[sitd_pkg::WORD_SEL_W-1:0]] = data;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_alphabet(bit stray);
        int unsigned offset;
        int unsigned k;
        int unsigned len;
        logic [sitd_pkg::WORD_W-1:0] word;
        wait_drained();
        offset = $urandom_range(sitd_pkg::WORD_COUNT - 1);
        for (int n = 0; n < sitd_pkg::WORD_COUNT; n++) begin
            k = (n + offset) % sitd_pkg::WORD_COUNT;
            for (int b = 0; b < 8; b++) word[b * 8 +: 8] = alpha_draft[k * 8 + b];
            write_register(sitd_pkg::CFG_IDX_W'(ALPHA_WORD_0 + k), word);
        end
        if (stray)
            write_register(sitd_pkg::CFG_IDX_W'($urandom_range(255, sitd_pkg::WORD_COUNT)),
                           {$urandom, $urandom});
        alphabets_loaded++;
        len = radix_length();
        if (alphabet_ok(len)) begin
            if (len < radix_lo) radix_lo = len;
            if (len > radix_hi) radix_hi = len;
        end
    endtask

    // the cleared alphabet is empty, so nothing may come out
    task automatic test_reset_alphabet();
        idle_pct = 0;
        send_value(32'd5);
        send_value(32'hFFFF_FFFF);
    endtask

    task automatic test_decimal_extremes();
        draft_text("0123456789");
        load_alphabet(1'b0);
        send_value(32'd0);
        send_value(32'd9);
        send_value(32'd10);
        send_value(-32'sd10);
        send_value(32'h7FFF_FFFF);
        send_value(32'h8000_0000);
        send_value(32'hFFFF_FFFF);
    endtask

    task automatic test_radix_extremes();
        draft_text("01");
        load_alphabet(1'b0);
        send_value(32'h8000_0000);
        send_value(32'h7FFF_FFFF);
        send_value(32'd1);
        draft_distinct(RADIX_CAP);
        load_alphabet(1'b0);
        send_value(32'h8000_0000);
        send_value(RADIX_CAP - 1);
        send_value(RADIX_CAP);
        send_value(32'hFFFF_FFFF);
    endtask

    task automatic test_bad_alphabets();
        for (int f = 0; f < FAULT_KINDS; f++) begin
            draft_distinct($urandom_range(12, 2));
            draft_corrupt(t_fault'(f));
            load_alphabet(1'b0);
            send_value($urandom);
        end
        // junk past the terminator and a write to an unused index must not matter
        draft_text("0123456789ABCDEF");
        for (int i = 17; i < SYMBOL_SLOTS; i++) alpha_draft[i] = 8'($urandom_range(255));
        load_alphabet(1'b1);
        send_value(32'hDEAD_BEEF);
        send_value(-32'sh1234_ABCD);
    endtask

    task automatic test_random_traffic(int unsigned items, int unsigned idle);
        int unsigned done;
        int unsigned batch;
        int unsigned len;
        bit          ok;
        idle_pct = idle;
        done     = 0;
        while (done < items) begin
            case ($urandom_range(9))
                0:       len = 2;
                1:       len = RADIX_CAP;
                2, 3:    len = $urandom_range(RADIX_CAP, 2);
                default: len = $urandom_range(16, 2);
            endcase
            draft_distinct(len);
            if ($urandom_range(5) == 0) draft_corrupt(t_fault'($urandom_range(FAULT_KINDS - 1)));
            load_alphabet($urandom_range(3) == 0);
            ok    = alphabet_ok(radix_length());
            batch = ok ? $urandom_range(24, 8) : 2;
            repeat (batch) begin
                send_value(random_value());
                if (ok) done++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph want;
        if (i_rst_n && o_symbol_valid) begin
            if (pending_glyphs.size() == 0) begin
                report_mismatch($sformatf("unexpected symbol %02h final %0b",
                                          o_symbol, o_final_symbol));
            end else begin
                want = pending_glyphs.pop_front();
                glyphs_checked++;
                if (o_symbol !== want.symbol)
                    report_mismatch($sformatf("symbol %02h, expected %02h",
                                              o_symbol, want.symbol));
                if (o_final_symbol !== want.last_char)
                    report_mismatch($sformatf("final flag %0b, expected %0b on symbol %02h",
                                              o_final_symbol, want.last_char, want.symbol));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_symbol_valid || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles + 1 >= STALL_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_value     = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int k = 0; k < sitd_pkg::WORD_COUNT; k++) alpha_word[k] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_alphabet();
        test_decimal_extremes();
        test_radix_extremes();
        test_bad_alphabets();
        test_random_traffic(90, 15);
        test_random_traffic(90, 55);
        test_random_traffic(90, 0);
        wait_drained();

        $display("Converted %0d values into %0d checked characters over %0d alphabet loads.",
                 values_sent, glyphs_checked, alphabets_loaded);
        $display("Valid radixes from %0d to %0d, plus malformed alphabets and stray writes.",
                 radix_lo, radix_hi);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
